// File: hw/rtl/trpc_pkg.sv
`timescale 1ns / 1ps

package trpc_pkg;

    // command store geometry
    localparam int BUFFER_DEPTH = 20;
    localparam int POS_W        = $clog2(BUFFER_DEPTH);
    // store positions the command matcher looks at
    localparam int PARSE_SPAN   = 8;

    localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd200;
    localparam logic [9:0]  MAX_COUNT              = 10'd255;

    // item kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_PINS = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // characters of the command language
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_T      = 8'h54;

    typedef enum logic [2:0] {
        RESP_STARTED   = 3'd0,
        RESP_STOPPED   = 3'd1,
        RESP_MODE1     = 3'd2,
        RESP_MODE2     = 3'd3,
        RESP_CMD_ERROR = 3'd4,
        RESP_OVERFLOW  = 3'd5
    } resp_code_t;

    typedef logic [PARSE_SPAN-1:0][7:0] byte_window_t;

    // decoded command, meaningful when a ')' arrives
    typedef struct packed {
        resp_code_t  code;
        logic        do_start;
        logic        do_stop;
        logic        do_mode1;
        logic        do_mode2;
        logic [7:0]  count;
    } parse_t;

    // per-item result of the motion counters
    typedef struct packed {
        logic        motor_on;
        logic        valid;
        logic        kind;
        logic [7:0]  rivets;
        logic [7:0]  seconds;
    } report_t;

endpackage

// File: hw/rtl/turntable_rivet_position_controller.sv
`timescale 1ns / 1ps

// turntable rivet position controller: every accepted request is one event,
// a received serial byte, a sample of the rivet and revolution sensor pins or
// a timer tick, and it yields exactly one result, in order. bytes collect in a
// 20-entry command store that '(' restarts; ')' parses (START), (STOP), (M1)
// or (M2:n) with n of one to three digits and answers with a response code.
// mode 1 counts falling rivet edges and reports count and seconds on every
// falling revolution edge; mode 2 counts n rivet edges down, then drops the
// motor line and reports the seconds. ticks_per_second (reset 200) is written
// through cfg_write_enable / cfg_write_data; the user must write it only while
// no request is in flight, as the block itself does not enforce this. a request
// waits in the input register while the decode and counter logic work on it,
// then its result is loaded into the result register that drives the output.
// a new request is taken every cycle while the output side keeps up; the
// result register and the input register together let a request enter while
// the previous result still waits to be taken

module turntable_rivet_position_controller
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_write_enable,
    input  logic [15:0]  cfg_write_data,
    // request channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   kind,
    input  logic [7:0]   rx_byte,
    input  logic         rivet_pin,
    input  logic         revolution_pin,
    // result channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic         response_valid,
    output logic [2:0]   response_code,
    output logic         motor_on,
    output logic         report_valid,
    output logic         report_kind,
    output logic [7:0]   report_rivets,
    output logic [7:0]   report_seconds
);

    // configuration register
    logic [15:0]  tps_reg;

    // input register
    logic         in_valid_reg;
    logic [1:0]   kind_reg;
    logic [7:0]   rx_byte_reg;
    logic         rivet_reg;
    logic         rev_reg;

    // result register
    logic         out_valid_reg;
    logic         resp_valid_reg;
    logic [2:0]   resp_code_reg;
    logic         motor_reg;
    logic         rep_valid_reg;
    logic         rep_kind_reg;
    logic [7:0]   rep_rivets_reg;
    logic [7:0]   rep_seconds_reg;

    logic                    advance;
    logic                    byte_go;
    logic                    cmd_fire;
    trpc_pkg::byte_window_t  window;
    trpc_pkg::parse_t        cmd;
    trpc_pkg::report_t       report;

    // the held request moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign byte_go  = advance && (kind_reg == trpc_pkg::KIND_BYTE);
    assign cmd_fire = byte_go && (rx_byte_reg == trpc_pkg::CH_RPAREN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= trpc_pkg::TICKS_PER_SECOND_RESET;
        end
        else if (cfg_write_enable)
        begin
            tps_reg <= cfg_write_data;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg    <= kind;
            rx_byte_reg <= rx_byte;
            rivet_reg   <= rivet_pin;
            rev_reg     <= revolution_pin;
        end
    end

    trpc_command_buffer u_buffer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (byte_go),
        .rx_byte (rx_byte_reg),
        .window  (window)
    );

    trpc_cmd_parser u_parser
    (
        .window (window),
        .cmd    (cmd)
    );

    trpc_motion u_motion
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (advance),
        .cmd_fire         (cmd_fire),
        .kind             (kind_reg),
        .rivet_pin        (rivet_reg),
        .revolution_pin   (rev_reg),
        .cmd              (cmd),
        .ticks_per_second (tps_reg),
        .report           (report)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            resp_valid_reg  <= cmd_fire;
            resp_code_reg   <= cmd_fire ? cmd.code : 3'd0;
            motor_reg       <= report.motor_on;
            rep_valid_reg   <= report.valid;
            rep_kind_reg    <= report.kind;
            rep_rivets_reg  <= report.rivets;
            rep_seconds_reg <= report.seconds;
        end
    end

    assign out_valid      = out_valid_reg;
    assign response_valid = resp_valid_reg;
    assign response_code  = resp_code_reg;
    assign motor_on       = motor_reg;
    assign report_valid   = rep_valid_reg;
    assign report_kind    = rep_kind_reg;
    assign report_rivets  = rep_rivets_reg;
    assign report_seconds = rep_seconds_reg;

endmodule

// File: hw/rtl/trpc_command_buffer.sv
`timescale 1ns / 1ps

module trpc_command_buffer
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  logic [7:0]              rx_byte,
    output trpc_pkg::byte_window_t  window
);

    logic [7:0]                  store_reg [trpc_pkg::BUFFER_DEPTH];
    logic [trpc_pkg::POS_W-1:0]  wp_reg;
    logic [trpc_pkg::POS_W-1:0]  wp_next;
    logic [trpc_pkg::POS_W-1:0]  wp_eff;
    logic                        is_open;
    logic                        is_close;

    assign is_open  = (rx_byte == trpc_pkg::CH_LPAREN);
    assign is_close = (rx_byte == trpc_pkg::CH_RPAREN);
    // '(' restarts the command at position zero
    assign wp_eff   = is_open ? '0 : wp_reg;

    always_comb
    begin
        if (is_close)
        begin
            wp_next = trpc_pkg::POS_W'(1);
        end
        else if (wp_eff == trpc_pkg::POS_W'(trpc_pkg::BUFFER_DEPTH - 1))
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_eff + trpc_pkg::POS_W'(1);
        end
    end

    // store as seen after the current byte lands
    genvar gi;
    generate
        for (gi = 0; gi < trpc_pkg::PARSE_SPAN; gi++)
        begin : g_window
            if (gi < trpc_pkg::BUFFER_DEPTH)
            begin : g_have
                assign window[gi] = (wp_eff == trpc_pkg::POS_W'(gi)) ? rx_byte : store_reg[gi];
            end
            else
            begin : g_short
                assign window[gi] = 8'd0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < trpc_pkg::BUFFER_DEPTH; i++)
            begin
                store_reg[i] <= 8'd0;
            end
            wp_reg <= '0;
        end
        else if (wr)
        begin
            // a closing bracket leaves entry zero cleared
            for (int i = 0; i < trpc_pkg::BUFFER_DEPTH; i++)
            begin
                if (i == 0 && is_close)
                begin
                    store_reg[i] <= 8'd0;
                end
                else if (wp_eff == trpc_pkg::POS_W'(i))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
            wp_reg <= wp_next;
        end
    end

    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < trpc_pkg::POS_W'(trpc_pkg::BUFFER_DEPTH))
        else $error("write position beyond store");

    a_close_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && is_close) |=> (wp_reg == trpc_pkg::POS_W'(1) && store_reg[0] == 8'd0))
        else $error("close did not rewind the store");

    a_open_lands_first: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && is_open) |=> (store_reg[0] == trpc_pkg::CH_LPAREN))
        else $error("open bracket not stored at position zero");

endmodule

// File: hw/rtl/trpc_cmd_parser.sv
`timescale 1ns / 1ps

module trpc_cmd_parser
(
    input  trpc_pkg::byte_window_t  window,
    output trpc_pkg::parse_t        cmd
);

    logic        m_start;
    logic        m_stop;
    logic        m_mode1;
    logic        m2_head;
    logic        dig4;
    logic        dig5;
    logic        dig6;
    logic [3:0]  d4;
    logic [3:0]  d5;
    logic [3:0]  d6;
    logic [6:0]  val2;
    logic [9:0]  val3;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= trpc_pkg::CH_ZERO) && (b <= trpc_pkg::CH_NINE);
    endfunction

    assign m_start = window[0] == trpc_pkg::CH_LPAREN && window[1] == trpc_pkg::CH_S &&
                     window[2] == trpc_pkg::CH_T && window[3] == trpc_pkg::CH_A &&
                     window[4] == trpc_pkg::CH_R && window[5] == trpc_pkg::CH_T &&
                     window[6] == trpc_pkg::CH_RPAREN;
    assign m_stop  = window[0] == trpc_pkg::CH_LPAREN && window[1] == trpc_pkg::CH_S &&
                     window[2] == trpc_pkg::CH_T && window[3] == trpc_pkg::CH_O &&
                     window[4] == trpc_pkg::CH_P && window[5] == trpc_pkg::CH_RPAREN;
    assign m_mode1 = window[0] == trpc_pkg::CH_LPAREN && window[1] == trpc_pkg::CH_M &&
                     window[2] == trpc_pkg::CH_ONE && window[3] == trpc_pkg::CH_RPAREN;
    assign m2_head = window[0] == trpc_pkg::CH_LPAREN && window[1] == trpc_pkg::CH_M &&
                     window[2] == trpc_pkg::CH_TWO && window[3] == trpc_pkg::CH_COLON;

    assign dig4 = is_digit(window[4]);
    assign dig5 = is_digit(window[5]);
    assign dig6 = is_digit(window[6]);
    // ascii digits carry their value in the low nibble
    assign d4   = window[4][3:0];
    assign d5   = window[5][3:0];
    assign d6   = window[6][3:0];
    assign val2 = 7'(d4) * 7'd10 + 7'(d5);
    assign val3 = 10'(d4) * 10'd100 + 10'(d5) * 10'd10 + 10'(d6);

    always_comb
    begin
        cmd          = '0;
        cmd.code     = trpc_pkg::RESP_CMD_ERROR;
        priority if (m_start)
        begin
            cmd.code     = trpc_pkg::RESP_STARTED;
            cmd.do_start = 1'b1;
        end
        else if (m_stop)
        begin
            cmd.code    = trpc_pkg::RESP_STOPPED;
            cmd.do_stop = 1'b1;
        end
        else if (m_mode1)
        begin
            cmd.code     = trpc_pkg::RESP_MODE1;
            cmd.do_mode1 = 1'b1;
        end
        else if (m2_head && window[5] == trpc_pkg::CH_RPAREN)
        begin
            if (dig4)
            begin
                cmd.code     = trpc_pkg::RESP_MODE2;
                cmd.do_mode2 = 1'b1;
                cmd.count    = 8'(d4);
            end
        end
        else if (m2_head && window[6] == trpc_pkg::CH_RPAREN)
        begin
            if (dig4 && dig5)
            begin
                cmd.code     = trpc_pkg::RESP_MODE2;
                cmd.do_mode2 = 1'b1;
                cmd.count    = 8'(val2);
            end
        end
        else if (m2_head && window[7] == trpc_pkg::CH_RPAREN)
        begin
            if (dig4 && dig5 && dig6)
            begin
                if (val3 > trpc_pkg::MAX_COUNT)
                begin
                    cmd.code = trpc_pkg::RESP_OVERFLOW;
                end
                else
                begin
                    cmd.code     = trpc_pkg::RESP_MODE2;
                    cmd.do_mode2 = 1'b1;
                    cmd.count    = val3[7:0];
                end
            end
        end
        else
        begin
            cmd.code = trpc_pkg::RESP_CMD_ERROR;
        end
    end

endmodule

// File: hw/rtl/trpc_motion.sv
`timescale 1ns / 1ps

module trpc_motion
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic               cmd_fire,
    input  logic [1:0]         kind,
    input  logic               rivet_pin,
    input  logic               revolution_pin,
    input  trpc_pkg::parse_t   cmd,
    input  logic [15:0]        ticks_per_second,
    output trpc_pkg::report_t  report
);

    logic         running_reg;
    logic         running_next;
    logic         mode_two_reg;
    logic         mode_two_next;
    logic         motor_reg;
    logic         motor_next;
    logic [7:0]   left_reg;
    logic [7:0]   left_next;
    logic [7:0]   counted_reg;
    logic [7:0]   counted_next;
    logic [7:0]   seconds_reg;
    logic [7:0]   seconds_next;
    logic [15:0]  tick_reg;
    logic [15:0]  tick_next;
    logic [15:0]  tick_sum;
    logic         last_rivet_reg;
    logic         last_rivet_next;
    logic         last_rev_reg;
    logic         last_rev_next;
    logic         rivet_fall;
    logic         rev_fall;
    logic [7:0]   left_dec;

    assign rivet_fall = last_rivet_reg & ~rivet_pin;
    assign rev_fall   = last_rev_reg & ~revolution_pin;
    assign left_dec   = rivet_fall ? left_reg - 8'd1 : left_reg;
    assign tick_sum   = tick_reg + 16'd1;

    always_comb
    begin
        running_next    = running_reg;
        mode_two_next   = mode_two_reg;
        motor_next      = motor_reg;
        left_next       = left_reg;
        counted_next    = counted_reg;
        seconds_next    = seconds_reg;
        tick_next       = tick_reg;
        last_rivet_next = last_rivet_reg;
        last_rev_next   = last_rev_reg;
        report          = '0;

        unique case (kind)
            trpc_pkg::KIND_BYTE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.do_start)
                    begin
                        running_next  = 1'b1;
                        motor_next    = 1'b1;
                        mode_two_next = 1'b0;
                    end
                    if (cmd.do_stop)
                    begin
                        running_next = 1'b0;
                        motor_next   = 1'b0;
                        counted_next = 8'd0;
                        left_next    = 8'd0;
                    end
                    if (cmd.do_mode1)
                    begin
                        mode_two_next = 1'b0;
                    end
                    if (cmd.do_mode2)
                    begin
                        mode_two_next = 1'b1;
                        left_next     = cmd.count;
                        seconds_next  = 8'd0;
                    end
                end
            end
            trpc_pkg::KIND_PINS:
            begin
                if (running_reg && !mode_two_reg)
                begin
                    if (rev_fall)
                    begin
                        report.valid   = 1'b1;
                        report.rivets  = counted_reg;
                        report.seconds = seconds_reg;
                        seconds_next   = 8'd0;
                        counted_next   = 8'd0;
                    end
                    else if (rivet_fall)
                    begin
                        counted_next = counted_reg + 8'd1;
                    end
                end
                else if (running_reg && mode_two_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if (motor_reg)
                        begin
                            report.valid   = 1'b1;
                            report.kind    = 1'b1;
                            report.seconds = seconds_reg;
                        end
                        motor_next   = 1'b0;
                        seconds_next = 8'd0;
                    end
                end
                last_rivet_next = rivet_pin;
                last_rev_next   = revolution_pin;
            end
            trpc_pkg::KIND_TICK:
            begin
                if (tick_sum == ticks_per_second)
                begin
                    tick_next    = 16'd0;
                    seconds_next = seconds_reg + 8'd1;
                end
                else
                begin
                    tick_next = tick_sum;
                end
            end
            default:
            begin
                report = '0;
            end
        endcase

        // the seconds counter rests at zero while stopped
        if (!running_next)
        begin
            seconds_next = 8'd0;
        end
        report.motor_on = motor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            mode_two_reg   <= 1'b0;
            motor_reg      <= 1'b0;
            left_reg       <= 8'd0;
            counted_reg    <= 8'd0;
            seconds_reg    <= 8'd0;
            tick_reg       <= 16'd0;
            last_rivet_reg <= 1'b1;
            last_rev_reg   <= 1'b1;
        end
        else if (go)
        begin
            running_reg    <= running_next;
            mode_two_reg   <= mode_two_next;
            motor_reg      <= motor_next;
            left_reg       <= left_next;
            counted_reg    <= counted_next;
            seconds_reg    <= seconds_next;
            tick_reg       <= tick_next;
            last_rivet_reg <= last_rivet_next;
            last_rev_reg   <= last_rev_next;
        end
    end

    a_stopped_no_seconds: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (seconds_reg == 8'd0))
        else $error("seconds counting while stopped");

    a_report_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (go && report.valid) |-> (running_reg && kind == trpc_pkg::KIND_PINS))
        else $error("report outside a running pin sample");

    a_move_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (go && report.valid && report.kind) |=> !motor_reg)
        else $error("motor still on after finished move");

endmodule
